// ----- rtl/core/cppm_pkg.sv -----
`timescale 1ns / 1ps

package cppm_pkg;

	localparam int MAX_VERTICES     = 64;
	localparam int PIXEL_COORD_BITS = 12;

	localparam int VERT_BITS   = 14;
	localparam int PIX_IN_BITS = 12;
	localparam int FUNC_BITS   = 2;

	localparam int ADDR_BITS = $clog2(MAX_VERTICES);
	localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);

	// pixel coordinate bits that actually reach the arithmetic
	localparam int PIX_USE_BITS = (PIXEL_COORD_BITS < PIX_IN_BITS) ?
		PIXEL_COORD_BITS : PIX_IN_BITS;
	localparam int DIFF_BITS = ((PIX_USE_BITS + 1 > VERT_BITS) ?
		PIX_USE_BITS + 1 : VERT_BITS) + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int SUM_BITS  = PROD_BITS + 1;

	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_TEST   = 2'd2;

	typedef logic signed [VERT_BITS-1:0] vert_t;
	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;

	typedef struct packed {
		logic                 clear;
		logic                 append;
		logic                 start;
		logic                 issue;
		logic [ADDR_BITS-1:0] addr;
	} cmd_t;

	typedef struct packed {
		logic                busy;
		logic                outside;
		logic [CNT_BITS-1:0] vcount;
	} status_t;

endpackage

// ----- rtl/core/cppm_datapath.sv -----
`timescale 1ns / 1ps

module cppm_datapath
	import cppm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	input  logic [VERT_BITS-1:0]   vertex_x,
	input  logic [VERT_BITS-1:0]   vertex_y,
	input  logic [PIX_IN_BITS-1:0] pixel_x,
	input  logic [PIX_IN_BITS-1:0] pixel_y,
	output status_t                status
);

	vert_t mem_x [MAX_VERTICES];
	vert_t mem_y [MAX_VERTICES];

	logic [CNT_BITS-1:0]     vcount_q;
	logic [PIX_USE_BITS-1:0] px_q, py_q;

	vert_t rdx_s1, rdy_s1;
	logic  v_s1, first_s1;
	vert_t prev_x_q, prev_y_q;

	diff_t dxa_s2, dya_s2, eyab_s2, exba_s2;
	logic  v_s2;
	prod_t p1_s3, p2_s3;
	logic  v_s3;
	logic  outside_q;
	sum_t  side;

	logic full;
	assign full = (vcount_q == CNT_BITS'(MAX_VERTICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cmd.clear) begin
			vcount_q <= '0;
		end else if (cmd.append && !full) begin
			vcount_q <= vcount_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem_x[vcount_q[ADDR_BITS-1:0]] <= vert_t'(vertex_x);
			mem_y[vcount_q[ADDR_BITS-1:0]] <= vert_t'(vertex_y);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdx_s1 <= mem_x[cmd.addr];
			rdy_s1 <= mem_y[cmd.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= pixel_x[PIX_USE_BITS-1:0];
			py_q <= pixel_y[PIX_USE_BITS-1:0];
		end
		if (cmd.issue) begin
			first_s1 <= (cmd.addr == '0);
		end
		if (v_s1) begin
			prev_x_q <= rdx_s1;
			prev_y_q <= rdy_s1;
		end
		// edge from the previous vertex (a) to the one just read (b)
		dxa_s2  <= diff_t'($signed({1'b0, px_q})) - diff_t'(prev_x_q);
		dya_s2  <= diff_t'($signed({1'b0, py_q})) - diff_t'(prev_y_q);
		eyab_s2 <= diff_t'(prev_y_q) - diff_t'(rdy_s1);
		exba_s2 <= diff_t'(rdx_s1) - diff_t'(prev_x_q);
		p1_s3   <= prod_t'(dxa_s2) * prod_t'(eyab_s2);
		p2_s3   <= prod_t'(dya_s2) * prod_t'(exba_s2);
	end

	assign side = sum_t'(p1_s3) + sum_t'(p2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			outside_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && !first_s1;
			v_s3 <= v_s2;
			if (cmd.start) begin
				outside_q <= 1'b0;
			end else if (v_s3 && side[SUM_BITS-1]) begin
				outside_q <= 1'b1;
			end
		end
	end

	assign status.busy    = v_s1 || v_s2 || v_s3;
	assign status.outside = outside_q;
	assign status.vcount  = vcount_q;

endmodule

// ----- rtl/core/cppm_ctrl.sv -----
`timescale 1ns / 1ps

module cppm_ctrl
	import cppm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_BITS-1:0] func,
	input  logic                 pixel_set,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 inside_res,
	input  status_t              status,
	output cmd_t                 cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_WALK   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]          state_q;
	logic [CNT_BITS-1:0] issue_cnt_q;
	logic                issue_done_q;
	logic                force_in_q;
	logic                out_valid_q;
	logic                inside_q;
	logic                in_take;
	logic                out_free;
	logic                last_issue;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign cmd.clear  = in_take && (func == FUNC_CLEAR);
	assign cmd.append = in_take && (func == FUNC_APPEND);
	assign cmd.start  = in_take && (func == FUNC_TEST);
	assign cmd.issue  = (state_q == ST_WALK) && !issue_done_q;
	assign cmd.addr   = issue_cnt_q[ADDR_BITS-1:0];

	assign last_issue = (issue_cnt_q == status.vcount - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_cnt_q  <= '0;
			issue_done_q <= 1'b0;
			force_in_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						issue_cnt_q  <= '0;
						issue_done_q <= 1'b0;
						// no edges or a set pixel: inside without a walk
						if (pixel_set || status.vcount < CNT_BITS'(2)) begin
							force_in_q <= 1'b1;
							state_q    <= ST_FINISH;
						end else begin
							force_in_q <= 1'b0;
							state_q    <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (cmd.issue) begin
						if (last_issue) begin
							issue_done_q <= 1'b1;
						end else begin
							issue_cnt_q <= issue_cnt_q + 1'b1;
						end
					end
					if (issue_done_q && !status.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			inside_q <= force_in_q || !status.outside;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

// ----- rtl/core/convex_polygon_pixel_mask.sv -----
`timescale 1ns / 1ps

// Point-in-convex-polygon mask. Transactions with func 0 clear the vertex list
// and func 1 appends a hull vertex (dropped once 64 are held); neither gives a
// result. A func 2 transaction tests one pixel and returns one inside_res: a set
// pixel, or a list of fewer than two vertices, skips the walk and goes straight
// to the finish state; otherwise the vertex memory is read one vertex per cycle
// through a single read port and each edge goes through one shared
// cross-product pipeline. The input is not ready again until the result is put
// out, and becomes ready in the same cycle as it. Func 3 is ignored. A finished
// result sits in an output register while the next transaction is taken.
module convex_polygon_pixel_mask
	import cppm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FUNC_BITS-1:0]   func,
	input  logic [VERT_BITS-1:0]   vertex_x,
	input  logic [VERT_BITS-1:0]   vertex_y,
	input  logic [PIX_IN_BITS-1:0] pixel_x,
	input  logic [PIX_IN_BITS-1:0] pixel_y,
	input  logic                   pixel_set,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   inside_res
);

	cmd_t    cmd;
	status_t status;

	cppm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.pixel_set  (pixel_set),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inside_res (inside_res),
		.status     (status),
		.cmd        (cmd)
	);

	cppm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.vertex_x (vertex_x),
		.vertex_y (vertex_y),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.status   (status)
	);

`ifndef SYNTHESIS
	// no edge may still be in flight when a new transaction can be taken
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !status.busy)
		else $error("edge pipeline busy while accepting");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.vcount <= CNT_BITS'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!in_ready && CNT_BITS'(cmd.addr) < status.vcount))
		else $error("vertex read outside loaded list");

	a_list_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue || status.busy) |=> $stable(status.vcount))
		else $error("vertex list changed during a walk");
`endif

endmodule
